// ===== design/stli_pkg.sv =====
// ----------------------------------------------------------------------------
// Sample table interpolator package
// Item types, codes and widths shared by the interpolator modules.
// ----------------------------------------------------------------------------
package stli_pkg;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] sample_time;
    logic signed [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic               have_samples;
    logic               add_dropped;
    logic [6:0]         entry_total;
  } out_item_t;

  // Running best-neighbour record carried from cell to cell.
  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_v;
    logic               has_p;
    logic signed [31:0] tp;
    logic signed [31:0] vp;
    logic               has_n;
    logic signed [31:0] tn;
    logic signed [31:0] vn;
  } scan_t;

endpackage

// ===== design/sample_table_linear_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// Sample table linear interpolator
// Channel  Dir  Handshake        Payload
// in       in   in_valid/stall   in_item_t
// out      out  out_valid/stall  out_item_t
// An add, a clear or an unused kind offers its result in the cycle after it
// is taken. A query is registered, passes a token through the chain of
// TABLE_DEPTH cells, one cell a cycle, then goes through a setup state, a
// start state and the serial divider, or from setup straight to the result
// when no division is needed. Reset empties the table at once. A stalled
// result holds the block; the next item is taken once the result has gone.
// ----------------------------------------------------------------------------
module sample_table_linear_interpolator_unit
  import stli_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_e state_q, state_d;
  logic [CW-1:0] fill_q;
  logic signed [31:0] lo_q, hi_q, qt_q, ans_q;
  logic drop_q;
  logic scan_go_q;
  logic signed [65:0] p0_q, p1_q;
  logic signed [33:0] den_q;
  logic signed [32:0] diff_n, diff_p;
  logic accept, div_start, div_busy;
  logic signed [31:0] quo;
  scan_t last;

  logic  [TABLE_DEPTH:0] tok;
  scan_t                 rec [TABLE_DEPTH+1];

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign tok[0] = scan_go_q;
  assign rec[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic wr;
    assign wr = accept && (in_item_i.kind == KIND_ADD) && (fill_q == CW'(g));
    stli_cell u_cell (
      .clk_i, .rst_ni,
      .wr_i(wr), .wr_t_i(in_item_i.sample_time), .wr_v_i(in_item_i.sample_value),
      .tok_i(tok[g]), .live_i(CW'(g) < fill_q), .qt_i(qt_q),
      .rec_i(rec[g]), .tok_o(tok[g+1]), .rec_o(rec[g+1])
    );
  end

  assign last = rec[TABLE_DEPTH];

  assign diff_n = {last.tn[31], last.tn} - {qt_q[31], qt_q};
  assign diff_p = {qt_q[31], qt_q} - {last.tp[31], last.tp};

  stli_divider u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(p0_q + p1_q), .den_i(den_q),
    .busy_o(div_busy), .quo_o(quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = (in_item_i.kind == KIND_QUERY) ? ST_SCAN : ST_DONE;
      ST_SCAN:  if (tok[TABLE_DEPTH]) state_d = ST_SETUP;
      ST_SETUP: state_d = (fill_q > CW'(1) && !last.hit && last.has_p && last.has_n)
                          ? ST_MUL : ST_DONE;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV:   if (!div_busy) state_d = ST_DONE;
      ST_DONE:  if (!out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign div_start = (state_q == ST_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      scan_go_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      scan_go_q <= accept && (in_item_i.kind == KIND_QUERY);
      if (accept) begin
        unique case (in_item_i.kind)
          KIND_ADD: if (fill_q < CW'(TABLE_DEPTH)) begin
            fill_q <= fill_q + CW'(1);
            if (fill_q == '0 || in_item_i.sample_value < lo_q) lo_q <= in_item_i.sample_value;
            if (fill_q == '0 || in_item_i.sample_value > hi_q) hi_q <= in_item_i.sample_value;
          end
          KIND_CLEAR: begin
            fill_q <= '0;
            lo_q   <= '0;
            hi_q   <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      qt_q   <= in_item_i.sample_time;
      drop_q <= (in_item_i.kind == KIND_ADD) && (fill_q >= CW'(TABLE_DEPTH));
      ans_q  <= '0;
    end
    if (state_q == ST_SETUP) begin
      if (fill_q == '0)       ans_q <= '0;
      else if (fill_q == CW'(1)) ans_q <= last.hit ? last.hit_v
                                   : (last.has_p ? last.vp : last.vn);
      else if (last.hit)      ans_q <= last.hit_v;
      else if (!last.has_p)   ans_q <= last.vn;
      else                    ans_q <= last.vp;
      p0_q  <= diff_n * last.vp;
      p1_q  <= diff_p * last.vn;
      den_q <= 34'($signed({last.tn[31], last.tn}) - $signed({last.tp[31], last.tp}));
    end
    if (state_q == ST_DIV && !div_busy) ans_q <= quo;
  end

  always_comb begin
    out_item_o.interp_value = ans_q;
    out_item_o.min_value    = lo_q;
    out_item_o.max_value    = hi_q;
    out_item_o.have_samples = (fill_q != '0);
    out_item_o.add_dropped  = drop_q;
    out_item_o.entry_total  = 7'(fill_q);
  end

  assign out_valid_o = (state_q == ST_DONE);

endmodule

// ===== design/stli_cell.sv =====
// ----------------------------------------------------------------------------
// Sample table cell
// Holds one sample and compares it against the query time when the scan
// token passes by, handing the updated neighbour record onward.
// ----------------------------------------------------------------------------
module stli_cell
  import stli_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  logic signed [31:0] wr_t_i,
  input  logic signed [31:0] wr_v_i,
  input  logic               tok_i,
  input  logic               live_i,
  input  logic signed [31:0] qt_i,
  input  scan_t              rec_i,
  output logic               tok_o,
  output scan_t              rec_o
);

  logic signed [31:0] t_q, v_q;
  logic               tok_q;
  scan_t              rec_q, rec_d;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      t_q <= wr_t_i;
      v_q <= wr_v_i;
    end
    if (tok_i) begin
      rec_q <= rec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_comb begin
    rec_d = rec_i;
    if (tok_i && live_i && !rec_i.hit) begin
      if (t_q == qt_i) begin
        rec_d.hit   = 1'b1;
        rec_d.hit_v = v_q;
      end else if (t_q < qt_i) begin
        if (!rec_i.has_p || t_q > rec_i.tp) begin
          rec_d.has_p = 1'b1;
          rec_d.tp    = t_q;
          rec_d.vp    = v_q;
        end
      end else if (!rec_i.has_n || t_q < rec_i.tn) begin
        rec_d.has_n = 1'b1;
        rec_d.tn    = t_q;
        rec_d.vn    = v_q;
      end
    end
  end

  assign tok_o = tok_q;
  assign rec_o = rec_q;

endmodule

// ===== design/stli_divider.sv =====
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division of a 66-bit magnitude by a 33-bit magnitude, one
// quotient bit a cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module stli_divider
  import stli_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [65:0] num_i,
  input  logic signed [33:0] den_i,
  output logic               busy_o,
  output logic signed [31:0] quo_o
);

  logic [65:0] rem_q, quo_q;
  logic [32:0] den_q;
  logic        neg_q, busy_q;
  logic [6:0]  cnt_q;
  logic [66:0] trial;
  logic [65:0] nmag;

  assign nmag  = num_i[65] ? 66'(-num_i) : 66'(num_i);
  assign trial = {rem_q, quo_q[65]} - {34'd0, den_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= nmag;
      den_q <= den_i[32:0];
      neg_q <= num_i[65];
    end else if (busy_q) begin
      if (!trial[66]) begin
        rem_q <= trial[65:0];
        quo_q <= {quo_q[64:0], 1'b1};
      end else begin
        rem_q <= {rem_q[64:0], quo_q[65]};
        quo_q <= {quo_q[64:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd65;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 7'd1;
      busy_q <= (cnt_q != 7'd0);
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? 32'(-quo_q[31:0]) : quo_q[31:0];

endmodule

// ===== design/stli_checker.sv =====
// ----------------------------------------------------------------------------
// Interpolator port checker
// Watches the ports of the interpolator for handshake and result rules.
// ----------------------------------------------------------------------------
module stli_checker
  import stli_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("Stalled item changed.");

  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("Item taken while a result waits.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Second item taken before the first finished.");

  a_have: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.have_samples == (out_item_o.entry_total != 7'd0)))
    else $error("Sample flag disagrees with count.");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.add_dropped |-> out_item_o.have_samples)
    else $error("Dropped add with an empty table.");

endmodule

bind sample_table_linear_interpolator_unit stli_checker u_stli_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_item_o
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sample table interpolator testbench
// Drives adds, queries and clears into the unit, predicts every result from a
// local copy of the table and compares each output item field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import stli_pkg::*;

  localparam int DEPTH = 64;
  localparam int WATCH_LIMIT = 20000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  sample_table_linear_interpolator_unit #(.TABLE_DEPTH(DEPTH)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  logic signed [31:0] tbl_time [DEPTH];
  logic signed [31:0] tbl_value [DEPTH];
  int unsigned        tbl_fill = 0;
  logic signed [31:0] tbl_low = '0;
  logic signed [31:0] tbl_high = '0;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        error_count = 0;
  int        watch_count = 0;
  int        send_wait;
  int        recv_wait;
  int        hold_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic signed [31:0] interpolate(logic signed [31:0] t);
    bit has_p, has_n;
    logic signed [31:0] tp, vp, tn, vn;
    longint num, den;
    has_p = 0; has_n = 0; tp = 0; vp = 0; tn = 0; vn = 0;
    if (tbl_fill == 0) return 0;
    if (tbl_fill == 1) return tbl_value[0];
    for (int i = 0; i < tbl_fill; i++) begin
      if (tbl_time[i] == t) return tbl_value[i];
      if (tbl_time[i] < t) begin
        if (!has_p || tbl_time[i] > tp) begin
          has_p = 1; tp = tbl_time[i]; vp = tbl_value[i];
        end
      end else if (!has_n || tbl_time[i] < tn) begin
        has_n = 1; tn = tbl_time[i]; vn = tbl_value[i];
      end
    end
    if (!has_p) return vn;
    if (!has_n) return vp;
    den = longint'(tn) - longint'(tp);
    num = (longint'(tn) - longint'(t)) * longint'(vp)
        + (longint'(t) - longint'(tp)) * longint'(vn);
    return 32'(num / den);
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    r = '0;
    case (kind_e'(it.kind))
      KIND_ADD: begin
        if (tbl_fill >= DEPTH) begin
          r.add_dropped = 1'b1;
        end else begin
          tbl_time[tbl_fill] = it.sample_time;
          tbl_value[tbl_fill] = it.sample_value;
          if (tbl_fill == 0) begin
            tbl_low = it.sample_value;
            tbl_high = it.sample_value;
          end else begin
            if (it.sample_value < tbl_low) tbl_low = it.sample_value;
            if (it.sample_value > tbl_high) tbl_high = it.sample_value;
          end
          tbl_fill++;
        end
      end
      KIND_QUERY: r.interp_value = interpolate(it.sample_time);
      KIND_CLEAR: begin
        tbl_fill = 0; tbl_low = 0; tbl_high = 0;
      end
      default: ;
    endcase
    r.min_value = tbl_low;
    r.max_value = tbl_high;
    r.have_samples = (tbl_fill != 0);
    r.entry_total = 7'(tbl_fill);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic push_item(kind_e k, logic [31:0] t, logic [31:0] v);
    in_item_t it;
    it.kind = k; it.sample_time = t; it.sample_value = v;
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($urandom_range(0, 40)) << 16;
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i <= '0;
      send_wait <= 0;
    end else if (in_valid_i && !in_stall_o) begin
      expected_results.insert(expected_results.size(), predict_result(in_item_i));
      if (pending_items.size() > 0 && $urandom_range(0, 3) == 0) begin
        in_valid_i <= 1'b0;
        send_wait <= $urandom_range(1, 10);
      end else if (pending_items.size() > 0) begin
        in_item_i <= pending_items.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end else if (!in_valid_i) begin
      if (send_wait > 0) begin
        send_wait <= send_wait - 1;
      end else if (pending_items.size() > 0) begin
        in_valid_i <= 1'b1;
        in_item_i <= pending_items.pop_front();
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
      recv_wait <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        out_item_t e;
        if (expected_results.size() == 0) begin
          $display("unexpected result item at %0t", $time);
          error_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_item_o.interp_value !== e.interp_value)
            report_mismatch("interp_value", out_item_o.interp_value, e.interp_value);
          if (out_item_o.min_value !== e.min_value)
            report_mismatch("min_value", out_item_o.min_value, e.min_value);
          if (out_item_o.max_value !== e.max_value)
            report_mismatch("max_value", out_item_o.max_value, e.max_value);
          if (out_item_o.have_samples !== e.have_samples)
            report_mismatch("have_samples", 32'(out_item_o.have_samples),
                            32'(e.have_samples));
          if (out_item_o.add_dropped !== e.add_dropped)
            report_mismatch("add_dropped", 32'(out_item_o.add_dropped),
                            32'(e.add_dropped));
          if (out_item_o.entry_total !== e.entry_total)
            report_mismatch("entry_total", 32'(out_item_o.entry_total),
                            32'(e.entry_total));
        end
      end
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        if ($urandom_range(0, 2) == 0) begin
          out_stall_i <= 1'b1;
          recv_wait <= $urandom_range(1, 10);
        end else begin
          out_stall_i <= 1'b0;
        end
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off so the unit backs up while items keep coming.
  initial begin
    wait (rst_ni === 1'b1);
    repeat (300) @(posedge clk_i);
    hold_cycles <= 400;
    @(posedge clk_i);
    while (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      watch_count <= 0;
    end else begin
      watch_count <= watch_count + 1;
      if (watch_count >= WATCH_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int n, mode;
    logic [31:0] base;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    // Directed part: empty query, single entry, exact match, extremes, gaps.
    push_item(KIND_QUERY, 32'h0001_0000, 32'h0);
    push_item(KIND_ADD, 32'h0002_0000, 32'h0005_0000);
    push_item(KIND_QUERY, 32'h7fff_ffff, 32'hffff_ffff);
    push_item(KIND_ADD, 32'h0006_0000, 32'hfffb_0000);
    push_item(KIND_QUERY, 32'h0003_0000, 32'h0);
    push_item(KIND_QUERY, 32'h0002_0000, 32'h0);
    push_item(KIND_QUERY, 32'h8000_0000, 32'h0);
    push_item(KIND_QUERY, 32'h7fff_ffff, 32'h0);
    push_item(KIND_ADD, 32'h0002_0000, 32'h0009_0000);
    push_item(KIND_QUERY, 32'h0002_0000, 32'h0);
    push_item(KIND_ADD, 32'h8000_0000, 32'h7fff_ffff);
    push_item(KIND_ADD, 32'h7fff_ffff, 32'h8000_0000);
    push_item(KIND_QUERY, 32'h0000_0001, 32'h0);
    push_item(KIND_QUERY, 32'hc000_0000, 32'h0);
    push_item(KIND_QUERY, 32'h4000_0000, 32'h0);
    push_item(KIND_NONE, 32'hffff_ffff, 32'hffff_ffff);
    push_item(KIND_CLEAR, 32'h0, 32'h0);
    push_item(KIND_QUERY, 32'h0, 32'h0);
    for (int i = 0; i < DEPTH + 2; i++)
      push_item(KIND_ADD, rand_word(0), rand_word(0));
    push_item(KIND_QUERY, rand_word(0), 32'h0);
    push_item(KIND_CLEAR, 32'h0, 32'h0);
    // Random part: fill phases with queries interleaved, then clear.
    n = 0;
    while (n < 1700) begin
      mode = $urandom_range(0, 3);
      base = $urandom_range(1, 70);
      for (int i = 0; i < base; i++) begin
        if ($urandom_range(0, 2) == 0)
          push_item(KIND_QUERY, rand_word(mode), rand_word(0));
        else
          push_item(KIND_ADD, rand_word(mode), rand_word($urandom_range(0, 3)));
        if ($urandom_range(0, 60) == 0)
          push_item(KIND_NONE, rand_word(0), rand_word(0));
        n++;
      end
      push_item(KIND_QUERY, rand_word(mode), 32'h0);
      push_item(KIND_CLEAR, rand_word(0), rand_word(0));
      n += 2;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    wait (pending_items.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
